// ===== hdl/uvsv_pkg.sv =====
// Types and constants shared by the UV sphere vertex generator modules.
package uvsv_pkg;

    localparam int CNT_W      = 11;
    localparam int VNUM_W     = 21;
    localparam int COORD_W    = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int PHASE_W    = 32;

    // Long division: 44 numerator bits, four quotient bits per stage.
    localparam int DIV_NUM_W          = 44;
    localparam int DIV_BITS_PER_STAGE = 4;
    localparam int DIV_LAT            = DIV_NUM_W / DIV_BITS_PER_STAGE;

    // CORDIC: Q30 datapath with guard bits, one iteration per stage.
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int TRIG_W       = 32;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [29:0] ATAN_TURNS [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
        30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
        30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
        30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    localparam logic [CFG_IDX_W-1:0] REG_STACK_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTOR_COUNT = 8'd1;

    localparam logic [CNT_W-1:0] STACK_COUNT_RST  = 11'd16;
    localparam logic [CNT_W-1:0] SECTOR_COUNT_RST = 11'd32;

    typedef enum logic [1:0] {
        QUAD_0 = 2'd0,
        QUAD_1 = 2'd1,
        QUAD_2 = 2'd2,
        QUAD_3 = 2'd3
    } t_quad;

    typedef struct packed {
        logic [CNT_W-1:0] stack_index;
        logic [CNT_W-1:0] sector_index;
    } t_vertex_req;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [VNUM_W-1:0]         vertex_number;
    } t_vertex_res;

endpackage

// ===== hdl/uv_sphere_vertex_generator.sv =====
// Top level of the UV sphere vertex generator: position of one sphere vertex per request.
//
// A request (stack index, sector index) is transferred at a rising edge where i_start is
// high and o_busy is low. The result (x, y, z in signed Q2.COORD_FRAC_BITS and the vertex
// number in the flat list) is shown on o_result for one cycle with o_done high. A new
// request may be given in every cycle; throughput is one vertex per clock.
// The pipeline is an input register, the 11-stage angle divider (four quotient bits a
// stage), the 26-stage CORDIC, one multiply stage and one rounding stage.
// The stack and sector counts are written through the configuration channel
// (i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data), which is always ready; index 0 is
// the stack count and index 1 the sector count, other indexes are ignored. Counts should
// only be changed while no request is in flight.
// Reset is synchronous and active low: it sets the counts to 16 and 32, drops every
// request in flight and holds o_busy high for its duration. The receiver cannot stall the
// result stream, so o_done carries no backpressure.
module uv_sphere_vertex_generator #(
    parameter int MAX_COUNT       = 1024,
    parameter int COORD_FRAC_BITS = 14
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  uvsv_pkg::t_vertex_req             i_item,
    output logic                              o_done,
    output uvsv_pkg::t_vertex_res             o_result,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [uvsv_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [uvsv_pkg::CNT_W-1:0]        i_cfg_data
);
    import uvsv_pkg::*;

    localparam int TOTAL_LAT = 1 + DIV_LAT + CORDIC_LAT + 2;
    localparam int VN_DEPTH  = TOTAL_LAT - 1;
    localparam int RES_DELAY = TOTAL_LAT;
    localparam logic [CNT_W-1:0] CNT_CLAMP =
        (MAX_COUNT > 2047) ? 11'd2047 : CNT_W'(MAX_COUNT);
    localparam int SH = 60 - COORD_FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (SH - 1);
    localparam logic signed [63:0] ONE  = 64'sd1 <<< COORD_FRAC_BITS;

    logic [CNT_W-1:0]     r_stack_count;
    logic [CNT_W-1:0]     r_sector_count;
    logic [CNT_W-1:0]     w_stacks;
    logic [CNT_W-1:0]     w_sectors;
    logic                 r_busy;
    logic                 w_accept;
    logic [TOTAL_LAT-1:0] r_vld;
    logic [DIV_NUM_W-1:0] r_num_stk;
    logic [DIV_NUM_W-1:0] r_num_sec;
    logic [VNUM_W-1:0]    r_vn [VN_DEPTH];
    logic [DIV_NUM_W-1:0] w_quo_stk;
    logic [DIV_NUM_W-1:0] w_quo_sec;
    logic [PHASE_W-1:0]   w_ph_stk;
    logic signed [TRIG_W-1:0] w_cst;
    logic signed [TRIG_W-1:0] w_sst;
    logic signed [TRIG_W-1:0] w_csc;
    logic signed [TRIG_W-1:0] w_ssc;
    logic signed [63:0]   r_prod_x;
    logic signed [63:0]   r_prod_y;
    logic signed [63:0]   r_prod_z;
    t_vertex_res          r_result;

    function automatic logic [COORD_W-1:0] to_coord(input logic signed [63:0] v);
        logic signed [63:0] r;
        r = (v + HALF) >>> SH;
        if (r > ONE) begin
            r = ONE;
        end else if (r < -ONE) begin
            r = -ONE;
        end
        return r[COORD_W-1:0];
    endfunction

    // A zero count behaves as one and a count above the limit as the limit.
    assign w_stacks  = (r_stack_count == '0) ? 11'd1 :
                       (r_stack_count > CNT_CLAMP) ? CNT_CLAMP : r_stack_count;
    assign w_sectors = (r_sector_count == '0) ? 11'd1 :
                       (r_sector_count > CNT_CLAMP) ? CNT_CLAMP : r_sector_count;

    assign w_accept    = i_start && !r_busy;
    assign o_busy      = r_busy;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count  <= STACK_COUNT_RST;
            r_sector_count <= SECTOR_COUNT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_STACK_COUNT:  r_stack_count  <= i_cfg_data;
                REG_SECTOR_COUNT: r_sector_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_vld  <= '0;
        end else begin
            r_busy <= 1'b0;
            r_vld  <= {r_vld[TOTAL_LAT-2:0], w_accept};
        end
    end

    // The half-divisor rounding term sits below the shifted index, so no adder is needed.
    always_ff @(posedge i_clk) begin
        r_num_sec <= {1'b0, i_item.sector_index, 32'(w_sectors >> 1)};
        r_num_stk <= {2'b0, i_item.stack_index, 31'(w_stacks >> 1)};
        r_vn[0]   <= VNUM_W'(i_item.stack_index * (12'(w_sectors) + 12'd1)
                             + 23'(i_item.sector_index));
        for (int k = 1; k < VN_DEPTH; k++) begin
            r_vn[k] <= r_vn[k-1];
        end
    end

    uvsv_divider u_div_stk (
        .i_clk (i_clk),
        .i_num (r_num_stk),
        .i_den (w_stacks),
        .o_quo (w_quo_stk)
    );

    uvsv_divider u_div_sec (
        .i_clk (i_clk),
        .i_num (r_num_sec),
        .i_den (w_sectors),
        .o_quo (w_quo_sec)
    );

    assign w_ph_stk = 32'h4000_0000 - w_quo_stk[PHASE_W-1:0];

    uvsv_cordic u_cordic_stk (
        .i_clk   (i_clk),
        .i_phase (w_ph_stk),
        .o_cos   (w_cst),
        .o_sin   (w_sst)
    );

    uvsv_cordic u_cordic_sec (
        .i_clk   (i_clk),
        .i_phase (w_quo_sec[PHASE_W-1:0]),
        .o_cos   (w_csc),
        .o_sin   (w_ssc)
    );

    always_ff @(posedge i_clk) begin
        r_prod_x <= w_cst * w_csc;
        r_prod_z <= w_cst * w_ssc;
        r_prod_y <= {{2{w_sst[TRIG_W-1]}}, w_sst, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        r_result.pos_x         <= to_coord(r_prod_x);
        r_result.pos_y         <= to_coord(r_prod_y);
        r_result.pos_z         <= to_coord(r_prod_z);
        r_result.vertex_number <= r_vn[VN_DEPTH-1];
    end

    assign o_done   = r_vld[TOTAL_LAT-1];
    assign o_result = r_result;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##RES_DELAY o_done)
        else $error("accepted request did not complete after the pipeline latency");

    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && o_busy))
        else $error("result strobe or ready seen straight after reset");

    a_first_vertex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_item.stack_index == '0 && i_item.sector_index == '0)
        |-> ##RES_DELAY (o_result.vertex_number == '0))
        else $error("vertex at the origin of the list has a non-zero number");

endmodule

// ===== hdl/uvsv_divider.sv =====
// Pipelined restoring divider producing four quotient bits per stage.
module uvsv_divider (
    input  logic                            i_clk,
    input  logic [uvsv_pkg::DIV_NUM_W-1:0]  i_num,
    input  logic [uvsv_pkg::CNT_W-1:0]      i_den,
    output logic [uvsv_pkg::DIV_NUM_W-1:0]  o_quo
);
    import uvsv_pkg::*;

    logic [CNT_W-1:0]     r_rem [DIV_LAT];
    logic [DIV_NUM_W-1:0] r_num [DIV_LAT];

    for (genvar g = 0; g < DIV_LAT; g++) begin : g_stage
        logic [CNT_W-1:0]     w_rem_in;
        logic [DIV_NUM_W-1:0] w_num_in;
        logic [CNT_W-1:0]     n_rem;
        logic [DIV_NUM_W-1:0] n_num;

        if (g == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_num_in = i_num;
        end else begin : g_next
            assign w_rem_in = r_rem[g-1];
            assign w_num_in = r_num[g-1];
        end

        // Numerator bits leave at the top while quotient bits enter at the bottom.
        always_comb begin
            logic [CNT_W:0] v_trial;
            n_rem = w_rem_in;
            n_num = w_num_in;
            for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                v_trial = {n_rem, n_num[DIV_NUM_W-1]};
                n_num   = {n_num[DIV_NUM_W-2:0], 1'b0};
                if (v_trial >= {1'b0, i_den}) begin
                    v_trial  = v_trial - {1'b0, i_den};
                    n_num[0] = 1'b1;
                end
                n_rem = v_trial[CNT_W-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g] <= n_rem;
            r_num[g] <= n_num;
        end
    end

    assign o_quo = r_num[DIV_LAT-1];

endmodule

// ===== hdl/uvsv_cordic.sv =====
// Pipelined rotation-mode CORDIC giving cosine and sine of a 32-bit phase.
module uvsv_cordic (
    input  logic                                i_clk,
    input  logic [uvsv_pkg::PHASE_W-1:0]        i_phase,
    output logic signed [uvsv_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [uvsv_pkg::TRIG_W-1:0]  o_sin
);
    import uvsv_pkg::*;

    logic signed [CORDIC_W-1:0] r_x [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] r_y [CORDIC_STEPS+1];
    logic signed [CORDIC_W-1:0] r_z [CORDIC_STEPS+1];
    t_quad                      r_q [CORDIC_STEPS+1];
    logic signed [TRIG_W-1:0]   r_cos;
    logic signed [TRIG_W-1:0]   r_sin;

    always_ff @(posedge i_clk) begin
        r_x[0] <= CORDIC_GAIN;
        r_y[0] <= '0;
        r_z[0] <= {4'b0, i_phase[29:0]};
        r_q[0] <= t_quad'(i_phase[PHASE_W-1:PHASE_W-2]);
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_iter
        logic signed [CORDIC_W-1:0] w_dx;
        logic signed [CORDIC_W-1:0] w_dy;
        logic signed [CORDIC_W-1:0] w_ang;

        assign w_dx  = r_y[k] >>> k;
        assign w_dy  = r_x[k] >>> k;
        assign w_ang = {4'b0, ATAN_TURNS[k]};

        always_ff @(posedge i_clk) begin
            if (!r_z[k][CORDIC_W-1]) begin
                r_x[k+1] <= r_x[k] - w_dx;
                r_y[k+1] <= r_y[k] + w_dy;
                r_z[k+1] <= r_z[k] - w_ang;
            end else begin
                r_x[k+1] <= r_x[k] + w_dx;
                r_y[k+1] <= r_y[k] - w_dy;
                r_z[k+1] <= r_z[k] + w_ang;
            end
            r_q[k+1] <= r_q[k];
        end
    end

    // Rotate the first-quadrant result into the quadrant given by the phase.
    always_ff @(posedge i_clk) begin
        unique case (r_q[CORDIC_STEPS])
            QUAD_0: begin
                r_cos <= TRIG_W'(r_x[CORDIC_STEPS]);
                r_sin <= TRIG_W'(r_y[CORDIC_STEPS]);
            end
            QUAD_1: begin
                r_cos <= TRIG_W'(-r_y[CORDIC_STEPS]);
                r_sin <= TRIG_W'(r_x[CORDIC_STEPS]);
            end
            QUAD_2: begin
                r_cos <= TRIG_W'(-r_x[CORDIC_STEPS]);
                r_sin <= TRIG_W'(-r_y[CORDIC_STEPS]);
            end
            default: begin
                r_cos <= TRIG_W'(r_y[CORDIC_STEPS]);
                r_sin <= TRIG_W'(-r_x[CORDIC_STEPS]);
            end
        endcase
    end

    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule
